// ===== design/ptf_pkg.sv =====
// ============================================================================
// ptf_pkg
// Shared types, codes and sine table math for the 2D point transform.
// ============================================================================
package ptf_pkg;

    localparam int unsigned PTF_FRAC_BITS = 16;

    localparam logic [1:0] ACT_TRANSLATE = 2'd0;
    localparam logic [1:0] ACT_SCALE     = 2'd1;
    localparam logic [1:0] ACT_ROTATE    = 2'd2;
    localparam logic [1:0] ACT_REFLECT   = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] oa;
        logic [31:0] ob;
    } ptf_req_t;

    typedef struct packed {
        ptf_req_t    req;
        logic [1:0]  quad;
        logic [6:0]  rem;
    } ptf_ang_t;

    typedef struct packed {
        logic [31:0] m00;
        logic [31:0] m01;
        logic [31:0] m02;
        logic [31:0] m10;
        logic [31:0] m11;
        logic [31:0] m12;
        logic [31:0] px;
        logic [31:0] py;
    } ptf_mat_t;

    // sin(k deg) in Q30 by a fixed eight-term Taylor series, elaboration only
    function automatic logic [63:0] sine_q30(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        if (k == 0)
        begin
            return 64'd0;
        end
        if (k >= 90)
        begin
            return ONE_Q30;
        end
        x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - term;
        return sum;
    endfunction

    // table entry rounded half up to frac fraction bits
    function automatic logic [31:0] sine_fixed(input int unsigned k, input int unsigned frac);
        logic [63:0] t;
        t = sine_q30(k);
        return 32'((t + (64'd1 << (29 - frac))) >> (30 - frac));
    endfunction

endpackage

// ===== design/ptf_angle.sv =====
// ============================================================================
// ptf_angle
// Angle reduction: mod 360, doubling for reflect, quadrant split (3 stages).
// ============================================================================
module ptf_angle
    import ptf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            vld_in,
    input  ptf_req_t        req_in,
    input  logic [15:0]     angle_in,
    output logic            vld_out,
    output ptf_ang_t        ang_out
);

    // 92*360 offset makes the angle positive; 46603 ~ 2^24/360 (low by <1)
    localparam logic [16:0] ANG_OFS = 17'd33120;
    localparam logic [15:0] RECIP   = 16'd46603;

    logic        vld_s1_reg, vld_s2_reg, vld_s3_reg;
    ptf_req_t    req_s1_reg, req_s2_reg;
    logic [16:0] u_s1_reg;
    logic [32:0] prod_s1_reg;
    logic [8:0]  deg_s2_reg;
    ptf_ang_t    ang_s3_reg;

    logic [16:0] u_next;
    logic [32:0] prod_next;
    logic [8:0]  q_est;
    logic [16:0] r0;
    logic [8:0]  deg_next;
    logic [9:0]  d2;
    logic [9:0]  d2_mod;
    logic [8:0]  dsel;
    ptf_ang_t    ang_next;

    always_comb
    begin
        u_next    = 17'($signed({angle_in[15], angle_in}) + $signed(ANG_OFS));
        prod_next = 33'(u_next) * 33'(RECIP);
    end

    always_comb
    begin
        q_est    = prod_s1_reg[32:24];
        r0       = u_s1_reg - 17'(q_est) * 17'd360;
        deg_next = (r0 >= 17'd360) ? 9'(r0 - 17'd360) : 9'(r0);
    end

    always_comb
    begin
        d2     = {deg_s2_reg, 1'b0};
        d2_mod = (d2 >= 10'd360) ? (d2 - 10'd360) : d2;
        dsel   = (req_s2_reg.action == ACT_REFLECT) ? d2_mod[8:0] : deg_s2_reg;
        ang_next.req = req_s2_reg;
        if (dsel < 9'd90)
        begin
            ang_next.quad = QUAD_0;
            ang_next.rem  = 7'(dsel);
        end
        else if (dsel < 9'd180)
        begin
            ang_next.quad = QUAD_1;
            ang_next.rem  = 7'(dsel - 9'd90);
        end
        else if (dsel < 9'd270)
        begin
            ang_next.quad = QUAD_2;
            ang_next.rem  = 7'(dsel - 9'd180);
        end
        else
        begin
            ang_next.quad = QUAD_3;
            ang_next.rem  = 7'(dsel - 9'd270);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
            vld_s3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_s1_reg <= vld_in;
            vld_s2_reg <= vld_s1_reg;
            vld_s3_reg <= vld_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_s1_reg  <= req_in;
            u_s1_reg    <= u_next;
            prod_s1_reg <= prod_next;
            req_s2_reg  <= req_s1_reg;
            deg_s2_reg  <= deg_next;
            ang_s3_reg  <= ang_next;
        end
    end

    assign vld_out = vld_s3_reg;
    assign ang_out = ang_s3_reg;

endmodule

// ===== design/ptf_matrix.sv =====
// ============================================================================
// ptf_matrix
// Quarter-wave sine lookup and matrix entry build (1 stage).
// ============================================================================
module ptf_matrix
    import ptf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = PTF_FRAC_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            vld_in,
    input  ptf_ang_t        ang_in,
    output logic            vld_out,
    output ptf_mat_t        mat_out
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic [FRAC_BITS:0] sin_tbl [0:90];

    for (genvar k = 0; k <= 90; k++)
    begin : g_tbl
        localparam logic [31:0] SINV = sine_fixed(k, FRAC_BITS);
        assign sin_tbl[k] = SINV[FRAC_BITS:0];
    end

    logic        vld_reg;
    ptf_mat_t    mat_reg;
    logic [31:0] a_val, b_val, s_val, c_val;
    ptf_mat_t    mat_next;

    always_comb
    begin
        a_val = 32'(sin_tbl[ang_in.rem]);
        b_val = 32'(sin_tbl[7'd90 - ang_in.rem]);
        case (ang_in.quad)
            QUAD_0:
            begin
                s_val = a_val;
                c_val = b_val;
            end
            QUAD_1:
            begin
                s_val = b_val;
                c_val = -a_val;
            end
            QUAD_2:
            begin
                s_val = -a_val;
                c_val = -b_val;
            end
            default:
            begin
                s_val = -b_val;
                c_val = a_val;
            end
        endcase

        mat_next     = '0;
        mat_next.px  = ang_in.req.px;
        mat_next.py  = ang_in.req.py;
        case (ang_in.req.action)
            ACT_TRANSLATE:
            begin
                mat_next.m00 = ONE;
                mat_next.m11 = ONE;
                mat_next.m02 = ang_in.req.oa;
                mat_next.m12 = ang_in.req.ob;
            end
            ACT_SCALE:
            begin
                mat_next.m00 = ang_in.req.oa;
                mat_next.m11 = ang_in.req.ob;
            end
            ACT_ROTATE:
            begin
                mat_next.m00 = c_val;
                mat_next.m01 = -s_val;
                mat_next.m10 = s_val;
                mat_next.m11 = c_val;
            end
            default:
            begin
                mat_next.m00 = c_val;
                mat_next.m01 = s_val;
                mat_next.m10 = s_val;
                mat_next.m11 = -c_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat_reg <= mat_next;
        end
    end

    assign vld_out = vld_reg;
    assign mat_out = mat_reg;

endmodule

// ===== design/ptf_mac.sv =====
// ============================================================================
// ptf_mac
// Matrix times point: multiply, sum and round, saturate (3 stages).
// ============================================================================
module ptf_mac
    import ptf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = PTF_FRAC_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            vld_in,
    input  ptf_mat_t        mat_in,
    output logic            vld_out,
    output ptf_mat_t        mat_out,
    output logic [31:0]     res_x,
    output logic [31:0]     res_y,
    output logic            res_sat
);

    localparam int unsigned SW = 66 - FRAC_BITS;
    localparam logic [65:0] HALF = 66'd1 << (FRAC_BITS - 1);

    logic               vld_s5_reg, vld_s6_reg, vld_s7_reg;
    ptf_mat_t           mat_s5_reg, mat_s6_reg, mat_s7_reg;
    logic signed [63:0] pax_reg, pbx_reg, pay_reg, pby_reg;
    logic [SW-1:0]      sx_reg, sy_reg;
    logic [31:0]        x_reg, y_reg;
    logic               sat_reg;

    logic signed [63:0] pax_next, pbx_next, pay_next, pby_next;
    logic [65:0]        acc_x, acc_y;
    logic [31:0]        x_next, y_next;
    logic               ovf_x, ovf_y;

    always_comb
    begin
        pax_next = $signed(mat_in.m00) * $signed(mat_in.px);
        pbx_next = $signed(mat_in.m01) * $signed(mat_in.py);
        pay_next = $signed(mat_in.m10) * $signed(mat_in.px);
        pby_next = $signed(mat_in.m11) * $signed(mat_in.py);
    end

    // floor((acc + half) / 2^F) is the upper slice of the sum
    always_comb
    begin
        acc_x = {{2{pax_reg[63]}}, pax_reg} + {{2{pbx_reg[63]}}, pbx_reg}
              + ({{34{mat_s5_reg.m02[31]}}, mat_s5_reg.m02} << FRAC_BITS) + HALF;
        acc_y = {{2{pay_reg[63]}}, pay_reg} + {{2{pby_reg[63]}}, pby_reg}
              + ({{34{mat_s5_reg.m12[31]}}, mat_s5_reg.m12} << FRAC_BITS) + HALF;
    end

    always_comb
    begin
        ovf_x  = !((&sx_reg[SW-1:31]) || !(|sx_reg[SW-1:31]));
        ovf_y  = !((&sy_reg[SW-1:31]) || !(|sy_reg[SW-1:31]));
        x_next = ovf_x ? (sx_reg[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : sx_reg[31:0];
        y_next = ovf_y ? (sy_reg[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : sy_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s5_reg <= 1'b0;
            vld_s6_reg <= 1'b0;
            vld_s7_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_s5_reg <= vld_in;
            vld_s6_reg <= vld_s5_reg;
            vld_s7_reg <= vld_s6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat_s5_reg <= mat_in;
            pax_reg    <= pax_next;
            pbx_reg    <= pbx_next;
            pay_reg    <= pay_next;
            pby_reg    <= pby_next;
            mat_s6_reg <= mat_s5_reg;
            sx_reg     <= acc_x[65:FRAC_BITS];
            sy_reg     <= acc_y[65:FRAC_BITS];
            mat_s7_reg <= mat_s6_reg;
            x_reg      <= x_next;
            y_reg      <= y_next;
            sat_reg    <= ovf_x | ovf_y;
        end
    end

    assign vld_out = vld_s7_reg;
    assign mat_out = mat_s7_reg;
    assign res_x   = x_reg;
    assign res_y   = y_reg;
    assign res_sat = sat_reg;

endmodule

// ===== design/point_transform_2d.sv =====
// ============================================================================
// point_transform_2d
// 2D homogeneous translate / scale / rotate / reflect of a fixed-point point.
// ============================================================================
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  request   in_valid / in_ready     action point_x point_y operand_a/b angle
//  result    out_valid / out_ready   m00..m12 out_x out_y saturated
//
//  One request per cycle while the result is not stalled; 3 angle, 1 matrix, 3 multiply stages.
//  The four 32x32 multipliers of the multiply stage set the clock limit.
//  All stages advance together; a stalled result holds the whole pipe.
//  Reset clears only the stage valid bits.
// ============================================================================
module point_transform_2d
    import ptf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = PTF_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   action,
    input  logic [31:0]  point_x,
    input  logic [31:0]  point_y,
    input  logic [31:0]  operand_a,
    input  logic [31:0]  operand_b,
    input  logic [15:0]  angle_deg,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  m00,
    output logic [31:0]  m01,
    output logic [31:0]  m02,
    output logic [31:0]  m10,
    output logic [31:0]  m11,
    output logic [31:0]  m12,
    output logic [31:0]  out_x,
    output logic [31:0]  out_y,
    output logic         saturated
);

    logic     adv;
    ptf_req_t req;
    logic     ang_vld, mat_vld;
    ptf_ang_t ang;
    ptf_mat_t mat, mat_res;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign req.action = action;
    assign req.px     = point_x;
    assign req.py     = point_y;
    assign req.oa     = operand_a;
    assign req.ob     = operand_b;

    ptf_angle u_angle
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (in_valid),
        .req_in   (req),
        .angle_in (angle_deg),
        .vld_out  (ang_vld),
        .ang_out  (ang)
    );

    ptf_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (ang_vld),
        .ang_in   (ang),
        .vld_out  (mat_vld),
        .mat_out  (mat)
    );

    ptf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (mat_vld),
        .mat_in   (mat),
        .vld_out  (out_valid),
        .mat_out  (mat_res),
        .res_x    (out_x),
        .res_y    (out_y),
        .res_sat  (saturated)
    );

    assign m00 = mat_res.m00;
    assign m01 = mat_res.m01;
    assign m02 = mat_res.m02;
    assign m10 = mat_res.m10;
    assign m11 = mat_res.m11;
    assign m12 = mat_res.m12;

endmodule

// ===== design/ptf_checker.sv =====
// ============================================================================
// ptf_checker
// Port-level checks on the point transform, bound to the top level.
// ============================================================================
module ptf_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [1:0]   action,
    input  logic [31:0]  point_x,
    input  logic [31:0]  point_y,
    input  logic [31:0]  operand_a,
    input  logic [31:0]  operand_b,
    input  logic [15:0]  angle_deg,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [31:0]  m00,
    input  logic [31:0]  m01,
    input  logic [31:0]  m02,
    input  logic [31:0]  m10,
    input  logic [31:0]  m11,
    input  logic [31:0]  m12,
    input  logic [31:0]  out_x,
    input  logic [31:0]  out_y,
    input  logic         saturated
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(m00) && $stable(saturated))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("request refused with room in the pipe");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> out_x == 32'h7fff_ffff || out_x == 32'h8000_0000
            || out_y == 32'h7fff_ffff || out_y == 32'h8000_0000)
        else $error("saturated flag without a clipped coordinate");

    a_offset_only_translate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (m02 != 32'd0 || m12 != 32'd0) |-> m01 == 32'd0 && m10 == 32'd0)
        else $error("offset and shear entries set together");

endmodule

bind point_transform_2d ptf_checker u_ptf_checker (.*);
